// ===== rtl/core/bmftl_pkg.sv =====
// Shared constants, types and microcode for the block-mapped flash translation layer.
package bmftl_pkg;

    // Geometry. Both counts are powers of two.
    localparam int SECTORS_PER_BLOCK = 32;
    localparam int NUM_BLOCKS        = 64;

    localparam int OFF_W          = $clog2(SECTORS_PER_BLOCK);
    localparam int BLK_W          = $clog2(NUM_BLOCKS);
    localparam int SEC_AW         = BLK_W + OFF_W;
    localparam int TOTAL_SECTORS  = NUM_BLOCKS * SECTORS_PER_BLOCK;
    localparam int LOGICAL_BLOCKS = NUM_BLOCKS - 1;
    localparam int MAPPED_SECTORS = LOGICAL_BLOCKS * SECTORS_PER_BLOCK;
    localparam int MAP_AW         = (LOGICAL_BLOCKS > 1) ? $clog2(LOGICAL_BLOCKS) : 1;
    localparam int CNT_W          = OFF_W + 1;

    // Fixed field widths.
    localparam int LSN_W    = 11;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 3;
    localparam int PBLK_W   = 6;

    localparam logic [DATA_W-1:0] ERASED_BYTE = 8'h20;
    localparam logic [DATA_W-1:0] NULL_BYTE   = 8'h00;

    typedef enum logic [STATUS_W-1:0] {
        ST_READ_DATA      = 3'd0,
        ST_READ_FREE      = 3'd1,
        ST_WRITE_IN_PLACE = 3'd2,
        ST_WRITE_MERGE    = 3'd3,
        ST_OUT_OF_RANGE   = 3'd4
    } status_t;

    // Microprogram steps.
    typedef enum logic [3:0] {
        U_CLEAR,
        U_IDLE,
        U_MAPRD,
        U_MAPLD,
        U_SECRD,
        U_DECIDE,
        U_COPY,
        U_ERASE,
        U_REMAP,
        U_EMIT
    } upc_t;

    // Branch conditions; a true condition selects the branch target.
    typedef enum logic [2:0] {
        J_NEVER,
        J_NO_INPUT,
        J_CLEAR_BUSY,
        J_OUT_RANGE,
        J_NOT_MERGE,
        J_COPY_BUSY,
        J_ERASE_BUSY,
        J_OUT_BUSY
    } jump_t;

    typedef struct packed {
        logic  take_in;
        logic  clear_wr;
        logic  map_rd;
        logic  ld_pbn;
        logic  sec_rd;
        logic  decide;
        logic  copy;
        logic  erase;
        logic  remap;
        logic  emit;
        logic  cnt_clr;
        logic  cnt_inc;
        jump_t jump;
        upc_t  target;
        upc_t  nxt;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic clear_busy;
        logic out_range;
        logic merge;
        logic copy_busy;
        logic erase_busy;
        logic out_busy;
    } cond_t;

    function automatic logic is_empty(input logic [DATA_W-1:0] b);
        return (b == NULL_BYTE) || (b == ERASED_BYTE);
    endfunction

    // Control store.
    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        w        = '0;
        w.jump   = J_NEVER;
        w.target = U_IDLE;
        w.nxt    = U_IDLE;
        case (pc)
            U_CLEAR:
            begin
                w.clear_wr = 1'b1;
                w.jump     = J_CLEAR_BUSY;
                w.target   = U_CLEAR;
                w.nxt      = U_IDLE;
            end
            U_IDLE:
            begin
                w.take_in = 1'b1;
                w.cnt_clr = 1'b1;
                w.jump    = J_NO_INPUT;
                w.target  = U_IDLE;
                w.nxt     = U_MAPRD;
            end
            U_MAPRD:
            begin
                w.map_rd = 1'b1;
                w.jump   = J_OUT_RANGE;
                w.target = U_EMIT;
                w.nxt    = U_MAPLD;
            end
            U_MAPLD:
            begin
                w.ld_pbn = 1'b1;
                w.nxt    = U_SECRD;
            end
            U_SECRD:
            begin
                w.sec_rd = 1'b1;
                w.nxt    = U_DECIDE;
            end
            U_DECIDE:
            begin
                w.decide = 1'b1;
                w.jump   = J_NOT_MERGE;
                w.target = U_EMIT;
                w.nxt    = U_COPY;
            end
            U_COPY:
            begin
                w.copy    = 1'b1;
                w.cnt_inc = 1'b1;
                w.jump    = J_COPY_BUSY;
                w.target  = U_COPY;
                w.nxt     = U_ERASE;
            end
            U_ERASE:
            begin
                w.erase   = 1'b1;
                w.cnt_inc = 1'b1;
                w.jump    = J_ERASE_BUSY;
                w.target  = U_ERASE;
                w.nxt     = U_REMAP;
            end
            U_REMAP:
            begin
                w.remap = 1'b1;
                w.nxt   = U_EMIT;
            end
            U_EMIT:
            begin
                w.emit   = 1'b1;
                w.jump   = J_OUT_BUSY;
                w.target = U_EMIT;
                w.nxt    = U_IDLE;
            end
            default:
            begin
                w.nxt = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/bmftl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bmftl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/bmftl_useq.sv =====
// Microprogram sequencer: step counter, control store lookup and branch logic.
module bmftl_useq
    import bmftl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cond_t  cond,
    output uword_t ctrl
);

    upc_t upc_reg;
    upc_t upc_next;
    logic taken;

    // Outputs: the control word of the current step.
    always_comb
    begin
        ctrl = ucode(upc_reg);
    end

    // Next step.
    always_comb
    begin
        case (ctrl.jump)
            J_NEVER:      taken = 1'b0;
            J_NO_INPUT:   taken = !cond.in_valid;
            J_CLEAR_BUSY: taken = cond.clear_busy;
            J_OUT_RANGE:  taken = cond.out_range;
            J_NOT_MERGE:  taken = !cond.merge;
            J_COPY_BUSY:  taken = cond.copy_busy;
            J_ERASE_BUSY: taken = cond.erase_busy;
            J_OUT_BUSY:   taken = cond.out_busy;
            default:      taken = 1'b0;
        endcase
        upc_next = taken ? ctrl.target : ctrl.nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== rtl/core/bmftl_dpath.sv =====
// Datapath: transaction registers, block map and sector store, merge counter, result register.
module bmftl_dpath
    import bmftl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  uword_t              ctrl,
    output cond_t               cond,
    input  logic                in_valid,
    input  logic                in_action,
    input  logic [LSN_W-1:0]    in_lsn,
    input  logic [DATA_W-1:0]   in_wdata,
    input  logic                out_ready,
    output logic                out_valid,
    output status_t             out_status,
    output logic [DATA_W-1:0]   out_rdata,
    output logic [PBLK_W-1:0]   out_pblk
);

    // Latched transaction.
    logic              act_reg;
    logic [LSN_W-1:0]  lsn_reg;
    logic [DATA_W-1:0] wdata_reg;

    logic [BLK_W-1:0]  pbn_reg;
    logic [BLK_W-1:0]  spare_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [SEC_AW-1:0] clr_reg;

    status_t           res_status_reg;
    logic [DATA_W-1:0] res_rdata_reg;
    logic [PBLK_W-1:0] res_pblk_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [DATA_W-1:0] out_rdata_reg;
    logic [PBLK_W-1:0] out_pblk_reg;

    logic [MAP_AW-1:0] lbn;
    logic [OFF_W-1:0]  off;
    logic [OFF_W-1:0]  wr_off;
    logic              out_range;
    logic              out_busy;
    logic              clear_map;

    logic              map_wr_en;
    logic [MAP_AW-1:0] map_wr_addr;
    logic [BLK_W-1:0]  map_wr_data;
    logic [BLK_W-1:0]  map_rd_data;

    logic              sec_wr_en;
    logic [SEC_AW-1:0] sec_wr_addr;
    logic [DATA_W-1:0] sec_wr_data;
    logic              sec_rd_en;
    logic [SEC_AW-1:0] sec_rd_addr;
    logic [DATA_W-1:0] sec_rd_data;
    logic [DATA_W-1:0] copy_byte;

    assign lbn       = MAP_AW'(lsn_reg >> OFF_W);
    assign off       = lsn_reg[OFF_W-1:0];
    assign out_range = 32'(lsn_reg) >= MAPPED_SECTORS;
    assign out_busy  = out_valid_reg && !out_ready;
    assign clear_map = 32'(clr_reg) < LOGICAL_BLOCKS;
    assign wr_off    = OFF_W'(cnt_reg - CNT_W'(1));

    assign cond.in_valid   = in_valid;
    assign cond.clear_busy = clr_reg != SEC_AW'(TOTAL_SECTORS - 1);
    assign cond.out_range  = out_range;
    assign cond.merge      = act_reg && !is_empty(sec_rd_data);
    assign cond.copy_busy  = cnt_reg != CNT_W'(SECTORS_PER_BLOCK);
    assign cond.erase_busy = cnt_reg != CNT_W'(SECTORS_PER_BLOCK - 1);
    assign cond.out_busy   = out_busy;

    // Block map port control.
    always_comb
    begin
        map_wr_en   = 1'b0;
        map_wr_addr = lbn;
        map_wr_data = spare_reg;
        if (ctrl.clear_wr && clear_map)
        begin
            map_wr_en   = 1'b1;
            map_wr_addr = MAP_AW'(clr_reg);
            map_wr_data = BLK_W'(clr_reg);
        end
        else if (ctrl.remap)
        begin
            map_wr_en = 1'b1;
        end
    end

    // The merge copy puts the new byte at its own offset and turns empty sectors into erased ones.
    always_comb
    begin
        if (wr_off == off)
        begin
            copy_byte = wdata_reg;
        end
        else if (is_empty(sec_rd_data))
        begin
            copy_byte = ERASED_BYTE;
        end
        else
        begin
            copy_byte = sec_rd_data;
        end
    end

    // Sector store port control.
    always_comb
    begin
        sec_rd_en   = ctrl.sec_rd || ctrl.copy;
        sec_rd_addr = ctrl.copy ? {pbn_reg, cnt_reg[OFF_W-1:0]} : {pbn_reg, off};
        sec_wr_en   = 1'b0;
        sec_wr_addr = {pbn_reg, off};
        sec_wr_data = wdata_reg;
        if (ctrl.clear_wr)
        begin
            sec_wr_en   = 1'b1;
            sec_wr_addr = clr_reg;
            sec_wr_data = NULL_BYTE;
        end
        else if (ctrl.decide)
        begin
            sec_wr_en = act_reg && is_empty(sec_rd_data);
        end
        else if (ctrl.copy)
        begin
            // The first copy step only issues a read.
            sec_wr_en   = cnt_reg != '0;
            sec_wr_addr = {spare_reg, wr_off};
            sec_wr_data = copy_byte;
        end
        else if (ctrl.erase)
        begin
            sec_wr_en   = 1'b1;
            sec_wr_addr = {pbn_reg, cnt_reg[OFF_W-1:0]};
            sec_wr_data = ERASED_BYTE;
        end
    end

    // Offset counter wraps to zero after the copy sweep so the erase sweep starts at offset zero.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (ctrl.cnt_inc)
        begin
            cnt_next = (cnt_reg == CNT_W'(SECTORS_PER_BLOCK)) ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    bmftl_ram #(
        .WIDTH (BLK_W),
        .DEPTH (LOGICAL_BLOCKS),
        .AW    (MAP_AW)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_en   (ctrl.map_rd && !out_range),
        .rd_addr (lbn),
        .rd_data (map_rd_data)
    );

    bmftl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TOTAL_SECTORS),
        .AW    (SEC_AW)
    ) u_sector_ram (
        .clk     (clk),
        .wr_en   (sec_wr_en),
        .wr_addr (sec_wr_addr),
        .wr_data (sec_wr_data),
        .rd_en   (sec_rd_en),
        .rd_addr (sec_rd_addr),
        .rd_data (sec_rd_data)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            spare_reg     <= BLK_W'(NUM_BLOCKS - 1);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (ctrl.clear_wr)
            begin
                clr_reg <= clr_reg + SEC_AW'(1);
            end
            if (ctrl.remap)
            begin
                spare_reg <= pbn_reg;
            end
            if (ctrl.emit && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (ctrl.take_in && in_valid)
        begin
            act_reg   <= in_action;
            lsn_reg   <= in_lsn;
            wdata_reg <= in_wdata;
        end
        if (ctrl.ld_pbn)
        begin
            pbn_reg <= map_rd_data;
        end
        if (ctrl.map_rd && out_range)
        begin
            res_status_reg <= ST_OUT_OF_RANGE;
            res_rdata_reg  <= '0;
            res_pblk_reg   <= '0;
        end
        if (ctrl.decide)
        begin
            res_pblk_reg <= PBLK_W'(pbn_reg);
            if (!act_reg)
            begin
                if (is_empty(sec_rd_data))
                begin
                    res_status_reg <= ST_READ_FREE;
                    res_rdata_reg  <= '0;
                end
                else
                begin
                    res_status_reg <= ST_READ_DATA;
                    res_rdata_reg  <= sec_rd_data;
                end
            end
            else
            begin
                res_status_reg <= ST_WRITE_IN_PLACE;
                res_rdata_reg  <= '0;
            end
        end
        if (ctrl.remap)
        begin
            res_status_reg <= ST_WRITE_MERGE;
            res_rdata_reg  <= '0;
            res_pblk_reg   <= PBLK_W'(spare_reg);
        end
        if (ctrl.emit && !out_busy)
        begin
            out_status_reg <= res_status_reg;
            out_rdata_reg  <= res_rdata_reg;
            out_pblk_reg   <= res_pblk_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_rdata  = out_rdata_reg;
    assign out_pblk   = out_pblk_reg;

endmodule

// ===== rtl/core/block_mapped_flash_translation.sv =====
// Top level of the block-mapped flash translation layer.
//
// This block translates logical sector numbers into a sector store of 64 physical blocks of
// 32 one-byte sectors, 63 of which are mapped to logical blocks while one is kept spare.
// A byte of 0x00 or 0x20 marks an empty sector. Each input transaction is a read or a write
// of one logical sector and yields exactly one output transaction: read data, read free,
// written in place, written with merge, or out of range for sectors at or above 2016.
// A write to a used sector merges: the old block is copied into the spare with the new byte
// at its offset, the old block is erased to 0x20 and becomes the spare. After reset a
// clearing pass zeroes the sector store and loads the identity block map, and no
// transaction is taken until it ends. Out-of-range requests go from the map read straight
// to the result, reads and in-place writes pass through the map load, sector read and
// decision steps, and a merge adds the copy sweep and the erase sweep through the single
// write port of the sector store. One transaction is worked on at a time; the next one is
// taken while a finished result still waits in the output register.
module block_mapped_flash_translation
    import bmftl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // logical_sector[10:0], write_data[18:11], zero pad
    input  logic [0:0]  s_axis_tuser,  // action[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // read_data[7:0], physical_block[13:8], zero pad
    output logic [2:0]  m_axis_tuser   // status[2:0]
);

    uword_t            ctrl;
    cond_t             cond;
    status_t           out_status;
    logic [DATA_W-1:0] out_rdata;
    logic [PBLK_W-1:0] out_pblk;

    // The sequencer steps through the control store; each step's word drives the datapath.
    bmftl_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    bmftl_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cond       (cond),
        .in_valid   (s_axis_tvalid),
        .in_action  (s_axis_tuser[0]),
        .in_lsn     (s_axis_tdata[10:0]),
        .in_wdata   (s_axis_tdata[18:11]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (out_status),
        .out_rdata  (out_rdata),
        .out_pblk   (out_pblk)
    );

    // Input is taken only in the idle step of the microprogram.
    assign s_axis_tready = ctrl.take_in;
    assign m_axis_tdata  = {2'b00, out_pblk, out_rdata};
    assign m_axis_tuser  = out_status;

endmodule

// ===== rtl/core/bmftl_chk.sv =====
// Port-level checker for the flash translation layer, bound to the top level.
module bmftl_chk
    import bmftl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // Only the five defined status codes ever leave the block.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_OUT_OF_RANGE))
        else $error("undefined status code");

    // Only a read with data carries a data byte.
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_READ_DATA)) |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("data byte set on a result without read data");

    // An out-of-range result names no physical block.
    a_range_block: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_OUT_OF_RANGE)) |-> (m_axis_tdata == 16'h0000))
        else $error("out-of-range result names a block");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output transaction changed");

    // One result per request: the block never takes requests back to back.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken before the previous one finished");

endmodule

bind block_mapped_flash_translation bmftl_chk u_bmftl_chk (.*);
